// ===== design/pcgbr_pkg.sv =====
package pcgbr_pkg;

  // LCG constants
  localparam logic [63:0] PCG_MULT        = 64'd6364136223846793005;
  localparam logic [63:0] PCG_RESET_STATE = 64'd359;
  localparam logic [63:0] PCG_RESET_INC   = 64'd953;

  // XSH-RR shift amounts
  localparam int unsigned XS_SHIFT1 = 18;
  localparam int unsigned XS_SHIFT2 = 27;
  localparam int unsigned ROT_SHIFT = 59;

  // restoring divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_SEED   = 2'd0,
    OP_DRAW32 = 2'd1,
    OP_RANGE  = 2'd2,
    OP_DRAW64 = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_ADD,
    ST_SEED_ADD,
    ST_TAIL,
    ST_MOD,
    ST_DONE
  } fsm_e;

  // XSH-RR output permutation of the pre-step state
  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [63:0] mix;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] dbl;
    mix = (s >> XS_SHIFT1) ^ s;
    xs  = 32'(mix >> XS_SHIFT2);
    rot = 5'(s >> ROT_SHIFT);
    dbl = {xs, xs} >> rot;
    return dbl[31:0];
  endfunction

endpackage

// ===== design/pcg32_bounded_random_top.sv =====
// draw32 takes one generator step, draw64 two, seed two with the seed added between;
//   a step runs MUL0-MUL3 and ADD on a single shared 32x32 multiplier.
// Range draw: tail pass, a step per try, modulo pass (two radix-2 divider passes);
//   width 1 takes no step, widths 2 and 2^32 one. One request at a time.
// Reset (rst_ni low, async): state 359, increment 953, FSM idle, no result held.
module pcg32_bounded_random_top
  import pcgbr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] seed_value_i,
  input  logic [62:0] stream_id_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] random_value_o
);

  localparam logic [31:0] MULT_LO = PCG_MULT[31:0];
  localparam logic [31:0] MULT_HI = PCG_MULT[63:32];
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  fsm_e fsm_q, fsm_d;

  // generator state
  logic [63:0] lcg_state_q;
  logic [63:0] lcg_inc_q;

  // request context
  opcode_e     op_q;
  logic [63:0] seed_q;
  logic [31:0] lo_q;
  logic [31:0] width_q;
  logic        second_q;   // second LCG step of seed / draw64

  // step datapath
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [31:0] draw_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // divider
  logic [31:0]          div_n_q;
  logic [31:0]          div_r_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [32:0]          div_shift;
  logic                 div_ge;
  logic [31:0]          div_r_nx;
  logic [31:0]          tail_q;

  // result
  logic [63:0] res_q;
  logic [63:0] out_value_q;
  logic        out_valid_q;

  logic        in_acc;
  logic        out_load;
  logic        is_reject;
  logic [31:0] rng_lo, rng_hi, rng_width;

  // ---------------------------------------------------------------------------
  // Request decode: order the bounds and form the range width (wraps to 0 for
  // the full 32-bit range).
  // ---------------------------------------------------------------------------
  assign in_acc    = in_valid_i && in_ready_o;
  assign rng_lo    = (range_low_i > range_high_i) ? range_high_i : range_low_i;
  assign rng_hi    = (range_low_i > range_high_i) ? range_low_i : range_high_i;
  assign rng_width = rng_hi - rng_lo + 32'd1;

  // draw falls in the biased tail and must be redrawn
  assign is_reject = draw_q < tail_q;

  // Result register may take a new value when empty or being drained.
  assign out_load = (fsm_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------------------
  // Shared 32x32 multiplier. Low 64 bits of state*MULT are built as
  //   lo*lo + (hi*lo << 32) + (lo*hi << 32), one partial product per cycle.
  // ---------------------------------------------------------------------------
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Radix-2 restoring divider step: remainder of div_n_q by width_q.
  assign div_shift = {div_r_q, div_n_q[31]};
  assign div_ge    = div_shift >= {1'b0, width_q};
  assign div_r_nx  = div_ge ? 32'(div_shift - {1'b0, width_q}) : div_shift[31:0];

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_e'(opcode_i) == OP_RANGE) begin
            if (rng_width == 32'd1) begin
              fsm_d = ST_DONE;
            end else if (rng_width == 32'd0 || rng_width == 32'd2) begin
              fsm_d = ST_MUL0;
            end else begin
              fsm_d = ST_TAIL;
            end
          end else begin
            fsm_d = ST_MUL0;
          end
        end
      end
      ST_MUL0: fsm_d = ST_MUL1;
      ST_MUL1: fsm_d = ST_MUL2;
      ST_MUL2: fsm_d = ST_MUL3;
      ST_MUL3: fsm_d = ST_ADD;
      ST_ADD: begin
        unique case (op_q)
          OP_SEED:   fsm_d = second_q ? ST_DONE : ST_SEED_ADD;
          OP_DRAW32: fsm_d = ST_DONE;
          OP_DRAW64: fsm_d = second_q ? ST_DONE : ST_MUL0;
          OP_RANGE: begin
            if (width_q == 32'd0 || width_q == 32'd2) begin
              fsm_d = ST_DONE;
            end else if (is_reject) begin
              fsm_d = ST_MUL0;
            end else begin
              fsm_d = ST_MOD;
            end
          end
          default: fsm_d = ST_DONE;
        endcase
      end
      ST_SEED_ADD: fsm_d = ST_MUL0;
      ST_TAIL:     fsm_d = (div_cnt_q == DIV_LAST) ? ST_MUL0 : ST_TAIL;
      ST_MOD:      fsm_d = (div_cnt_q == DIV_LAST) ? ST_DONE : ST_MOD;
      ST_DONE:     fsm_d = out_load ? ST_IDLE : ST_DONE;
      default:     fsm_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output / control decode
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o = (fsm_q == ST_IDLE);
    mul_a      = lcg_state_q[31:0];
    mul_b      = MULT_LO;
    unique case (fsm_q)
      ST_MUL1: mul_a = lcg_state_q[63:32];
      ST_MUL2: mul_b = MULT_HI;
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_value_q;

  // ---------------------------------------------------------------------------
  // Control and generator state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      out_valid_q <= 1'b0;
      lcg_state_q <= PCG_RESET_STATE;
      lcg_inc_q   <= PCG_RESET_INC;
    end else begin
      fsm_q <= fsm_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && opcode_e'(opcode_i) == OP_SEED) begin
        lcg_state_q <= 64'd0;
        lcg_inc_q   <= {stream_id_i, 1'b1};
      end else if (fsm_q == ST_ADD) begin
        lcg_state_q <= acc_q + lcg_inc_q;
      end else if (fsm_q == ST_SEED_ADD) begin
        lcg_state_q <= lcg_state_q + seed_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= res_q;
    end
    unique case (fsm_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_q      <= opcode_e'(opcode_i);
          seed_q    <= seed_value_i;
          lo_q      <= rng_lo;
          width_q   <= rng_width;
          second_q  <= 1'b0;
          div_n_q   <= 32'd0 - rng_width;
          div_r_q   <= 32'd0;
          div_cnt_q <= '0;
          res_q     <= (opcode_e'(opcode_i) == OP_RANGE && rng_width == 32'd1) ?
                       {32'd0, rng_lo} : 64'd0;
        end
      end
      ST_MUL0: begin
        draw_q <= xsh_rr(lcg_state_q);
        prod_q <= mul_p;
      end
      ST_MUL1: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_MUL2: begin
        acc_q  <= acc_q + {prod_q[31:0], 32'd0};
        prod_q <= mul_p;
      end
      ST_MUL3: begin
        acc_q <= acc_q + {prod_q[31:0], 32'd0};
      end
      ST_ADD: begin
        unique case (op_q)
          OP_SEED: second_q <= 1'b1;
          OP_DRAW32: res_q <= {32'd0, draw_q};
          OP_DRAW64: begin
            if (!second_q) begin
              res_q[63:32] <= draw_q;
              second_q     <= 1'b1;
            end else begin
              res_q[31:0] <= draw_q;
            end
          end
          OP_RANGE: begin
            if (width_q == 32'd0) begin
              res_q <= {32'd0, draw_q};
            end else if (width_q == 32'd2) begin
              res_q <= {32'd0, lo_q + {31'd0, draw_q[0]}};
            end else if (!is_reject) begin
              div_n_q   <= draw_q;
              div_r_q   <= 32'd0;
              div_cnt_q <= '0;
            end
          end
          default: ;
        endcase
      end
      ST_TAIL: begin
        div_n_q   <= {div_n_q[30:0], 1'b0};
        div_r_q   <= div_r_nx;
        div_cnt_q <= div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_LAST) begin
          tail_q <= div_r_nx;
        end
      end
      ST_MOD: begin
        div_n_q   <= {div_n_q[30:0], 1'b0};
        div_r_q   <= div_r_nx;
        div_cnt_q <= div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_LAST) begin
          res_q <= {32'd0, lo_q + div_r_nx};
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("accepted a request but stayed ready");

  a_inc_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcg_inc_q[0])
    else $error("LCG increment became even");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_TAIL || fsm_q == ST_MOD) |-> (div_r_q < width_q))
    else $error("divider remainder not below divisor");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_DONE && out_valid_q && !out_ready_i) |=> (fsm_q == ST_DONE))
    else $error("result dropped while output stalled");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench
  import pcgbr_pkg::*;
();

  typedef struct packed {
    opcode_e     opcode;
    logic [63:0] seed_value;
    logic [62:0] stream_id;
    logic [31:0] range_low;
    logic [31:0] range_high;
  } pcg_request_t;

  localparam int unsigned RANDOM_REQUESTS = 1400;
  localparam int unsigned IDLE_PERCENT    = 27;
  // Calm window: no idling on either side while this many requests are in.
  localparam int unsigned CALM_START      = 500;
  localparam int unsigned CALM_END        = 700;
  // A range draw repeats its generator step on each retry; allow for long retry runs
  // plus receiver stalls, several times over.
  localparam int unsigned STALL_LIMIT     = 5000;
  localparam int unsigned DRAIN_CYCLES    = 100;

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid;
  logic         in_ready_o;
  pcg_request_t req_q;
  logic         out_valid_o;
  logic         out_ready;
  logic [63:0]  random_value_o;

  pcg_request_t pending_q[$];
  logic [63:0]  expected_values_q[$];

  // Shadow generator state.
  logic [63:0]  lcg_state_q;
  logic [63:0]  lcg_inc_q;

  int unsigned  requests_sent;
  int unsigned  results_checked;
  int unsigned  error_count;
  int unsigned  stall_cycles;
  int unsigned  op_count [4];
  logic         calm;

  assign calm = (requests_sent >= CALM_START) && (requests_sent < CALM_END);

  pcg32_bounded_random_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .opcode_i       (req_q.opcode),
    .seed_value_i   (req_q.seed_value),
    .stream_id_i    (req_q.stream_id),
    .range_low_i    (req_q.range_low),
    .range_high_i   (req_q.range_high),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .random_value_o (random_value_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Generator model
  // ---------------------------------------------------------------------------

  // One LCG step; the output is the XSH-RR permutation of the old state.
  function automatic logic [31:0] gen_step();
    logic [63:0] prev;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [4:0]  back;
    prev        = lcg_state_q;
    lcg_state_q = prev * PCG_MULT + lcg_inc_q;
    xs          = 32'(((prev >> 18) ^ prev) >> 27);
    rot         = prev[63:59];
    back        = 5'd0 - rot;
    return (xs >> rot) | (xs << back);
  endfunction

  // Unbiased draw in [lo, hi] by rejection; bounds may come in either order.
  function automatic logic [31:0] bounded_draw(input logic [31:0] lo, input logic [31:0] hi);
    logic [31:0] tmp;
    logic [31:0] span;
    logic [31:0] reject_below;
    logic [31:0] draw;
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    span = hi - lo + 32'd1;
    if (span == 32'd0) return gen_step();   // full 32-bit range wraps to zero
    if (span == 32'd1) return lo;           // single value, no step
    if (span == 32'd2) return lo + (gen_step() & 32'd1);
    reject_below = (32'd0 - span) % span;
    do begin
      draw = gen_step();
    end while (draw < reject_below);
    return lo + (draw % span);
  endfunction

  function automatic logic [63:0] predict_result(input pcg_request_t r);
    logic [31:0] first;
    logic [31:0] second;
    case (r.opcode)
      OP_SEED: begin
        lcg_state_q = '0;
        lcg_inc_q   = {r.stream_id, 1'b1};
        void'(gen_step());
        lcg_state_q = lcg_state_q + r.seed_value;
        void'(gen_step());
        return '0;
      end
      OP_DRAW32: begin
        return {32'd0, gen_step()};
      end
      OP_RANGE: begin
        return {32'd0, bounded_draw(r.range_low, r.range_high)};
      end
      default: begin
        // first output lands in the high half
        first  = gen_step();
        second = gen_step();
        return {first, second};
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  function automatic pcg_request_t make_req(input opcode_e op, input logic [63:0] seed,
                                            input logic [62:0] stream, input logic [31:0] lo,
                                            input logic [31:0] hi);
    pcg_request_t r;
    r.opcode     = op;
    r.seed_value = seed;
    r.stream_id  = stream;
    r.range_low  = lo;
    r.range_high = hi;
    return r;
  endfunction

  // Mostly draws, some reseeds; range bounds biased toward the special widths.
  // Unused fields stay random so the block has to ignore them.
  function automatic pcg_request_t random_request();
    pcg_request_t r;
    int unsigned  pick;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [31:0]  tmp;
    r    = make_req(OP_DRAW32, rand_word64(), 63'(rand_word64()), $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r.opcode = OP_SEED;
      case ($urandom_range(0, 5))
        0: r.seed_value = '0;
        1: r.seed_value = '1;
        2: r.stream_id  = '0;
        3: r.stream_id  = '1;
        default: ;
      endcase
    end else if (pick < 33) begin
      r.opcode = OP_DRAW32;
    end else if (pick < 75) begin
      r.opcode = OP_RANGE;
      lo = $urandom;
      case ($urandom_range(0, 7))
        0: hi = $urandom;
        1: hi = lo + $urandom_range(2, 12);                      // small widths
        2: hi = lo;                                              // one value
        3: hi = lo + 32'd1;                                      // two values
        4: begin                                                 // full range
          lo = '0;
          hi = '1;
        end
        5: begin                                                 // heavy rejection
          lo = $urandom_range(0, 1000);
          hi = lo + 32'h8000_0000 + $urandom_range(0, 255);
        end
        6: hi = lo + ((32'd1 << $urandom_range(1, 31)) - 32'd1); // power-of-two widths
        default: hi = lo + $urandom_range(0, 65535);
      endcase
      if ($urandom_range(0, 1) == 1) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      r.range_low  = lo;
      r.range_high = hi;
    end else begin
      r.opcode = OP_DRAW64;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: pops the pending queue, holds payload until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    pcg_request_t next_req;
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      req_q       <= '0;
      lcg_state_q = PCG_RESET_STATE;
      lcg_inc_q   = PCG_RESET_INC;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_values_q.push_back(predict_result(req_q));
        op_count[req_q.opcode] = op_count[req_q.opcode] + 1;
        requests_sent          = requests_sent + 1;
      end
      if (in_valid && !in_ready_o) begin
        // request still waiting, keep it as is
      end else if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        next_req = pending_q.pop_front();
        req_q    <= next_req;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: in-order compare against the predicted values.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    logic [63:0] want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_values_q.size() == 0) begin
          $error("unexpected result: random_value %h", random_value_o);
          error_count = error_count + 1;
        end else begin
          want = expected_values_q.pop_front();
          if (want !== random_value_o) begin
            $error("random_value mismatch: expected %h, actual %h", want, random_value_o);
            error_count = error_count + 1;
          end
          results_checked = results_checked + 1;
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Watchdog: too long without any handshake means the block is stuck.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a handshake", stall_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed corners, drain, random traffic, final drain.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    requests_sent   = 0;
    results_checked = 0;
    error_count     = 0;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: draws from the reset state first, then range corner cases, then reseeds mixed with more draws.
    pending_q.push_back(make_req(OP_DRAW32, '0, '0, '0, '0));
    pending_q.push_back(make_req(OP_DRAW64, '1, '1, '1, '1));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'h0000_0000, 32'hFFFF_FFFF));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'hFFFF_FFFF, 32'h0000_0000));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'd5, 32'd5));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'd0, 32'd0));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'd10, 32'd11));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'd11, 32'd10));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'd0, 32'd2));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'd100, 32'd7));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'd0, 32'h8000_0000));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'd1, 32'hFFFF_FFFF));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'd0, 32'hFFFF_FFFE));
    pending_q.push_back(make_req(OP_SEED, '0, '0, '1, '1));
    pending_q.push_back(make_req(OP_DRAW32, '0, '0, '0, '0));
    pending_q.push_back(make_req(OP_SEED, '1, '1, '0, '0));
    pending_q.push_back(make_req(OP_DRAW64, '0, '0, '0, '0));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_q.push_back(make_req(OP_SEED, rand_word64(), 63'(rand_word64()), '0, '0));
    pending_q.push_back(make_req(OP_DRAW32, '1, '1, '1, '1));
    pending_q.push_back(make_req(OP_RANGE, '0, '0, 32'd1000, 32'd1));
    pending_q.push_back(make_req(OP_DRAW64, '0, '0, '0, '0));

    // Hold off new requests until everything in flight has come back.
    // Checked at the falling edge so the driver and monitor updates have settled.
    while (pending_q.size() != 0 || in_valid || expected_values_q.size() != 0)
      @(negedge clk_i);

    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      pending_q.push_back(random_request());
    end

    while (pending_q.size() != 0 || in_valid || expected_values_q.size() != 0)
      @(negedge clk_i);
    // catch any stray extra result
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_values_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_values_q.size());
      error_count = error_count + 1;
    end

    $display("requests: %0d (seed %0d, draw32 %0d, range %0d, draw64 %0d)", requests_sent,
             op_count[OP_SEED], op_count[OP_DRAW32], op_count[OP_RANGE], op_count[OP_DRAW64]);
    $display("results compared: %0d, errors: %0d", results_checked, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pcgbr_pkg.sv
design/pcg32_bounded_random_top.sv
tb/sv/testbench.sv
